/* src/ordered_queue_with_indexed_insert_top_assert.svh */
// assertion macros for the ordered queue block
// used by the port checker; needs a clock and an active-low reset in scope
`ifndef ORDERED_QUEUE_WITH_INDEXED_INSERT_TOP_ASSERT_SVH
`define ORDERED_QUEUE_WITH_INDEXED_INSERT_TOP_ASSERT_SVH

// same-cycle implication
`define OQI_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define OQI_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/oqi_pkg.sv */
// shared types and constants of the ordered queue block
// no dependencies; imported by every module of the block
`default_nettype none

package oqi_pkg;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2,
    OP_SEARCH = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_INVALID   = 3'd1,
    ST_PAST_END  = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_FULL      = 3'd4,
    ST_NOT_FOUND = 3'd5
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_t;

  localparam int ID_BITS   = 16;
  localparam int POS_BITS  = 7;
  localparam int POSITION_BITS = 8;
  localparam int IN_BYTES_W  = 32;
  localparam int OUT_BYTES_W = 40;

  // search scan handles this many cells per cycle
  localparam int SCAN_LANES = 8;
  localparam int LANE_W     = 3;

  typedef struct packed {
    logic ins;
    logic rem;
    logic srch;
  } cell_ctl_t;

  typedef struct packed {
    logic done;
    logic hit;
  } scan_res_t;

  // status in the low bits
  typedef struct packed {
    logic [POS_BITS-1:0] occupancy;
    logic [POS_BITS-1:0] result_position;
    logic [ID_BITS-1:0]  result_id;
    status_t             status;
  } result_t;

endpackage

`default_nettype wire

/* src/oqi_cell.sv */
// one storage cell of the ordered queue chain
// depends on oqi_pkg; shifts with its neighbors on insert and remove
`default_nettype none

module oqi_cell #(
  parameter int IDX   = 0,
  parameter int SW    = 16,
  parameter int CNT_W = 7
) (
  input  wire logic              clk,
  input  wire oqi_pkg::cell_ctl_t ctl,
  input  wire logic [SW-1:0]     key,
  input  wire logic [CNT_W-1:0]  at,
  input  wire logic [CNT_W-1:0]  count,
  input  wire logic [SW-1:0]     left_data,
  input  wire logic [SW-1:0]     right_data,
  output logic      [SW-1:0]     data,
  output logic                   match
);
  import oqi_pkg::*;

  localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

  logic [SW-1:0] data_r;
  logic [SW-1:0] data_nxt;
  logic          match_r;
  logic          match_nxt;

  always_comb begin
    data_nxt  = data_r;
    match_nxt = match_r;
    if (ctl.ins) begin
      if (MY_IDX == at) begin
        data_nxt = key;
      end else if (MY_IDX > at) begin
        data_nxt = left_data;
      end
    end
    if (ctl.rem) begin
      data_nxt = right_data;
    end
    if (ctl.srch) begin
      // cells past the occupancy never match
      match_nxt = (data_r == key) && (MY_IDX < count);
    end
  end

  always_ff @(posedge clk) begin
    data_r  <= data_nxt;
    match_r <= match_nxt;
  end

  assign data  = data_r;
  assign match = match_r;

endmodule

`default_nettype wire

/* src/oqi_scan.sv */
// first-match scanner over the cell match flags, a group of lanes per cycle
// depends on oqi_pkg
`default_nettype none

module oqi_scan #(
  parameter int CAPACITY = 64,
  parameter int CNT_W    = 7,
  parameter int SEG_W    = 3
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  input  wire logic                    busy,
  input  wire logic [CAPACITY-1:0]     match_vec,
  input  wire logic [CNT_W-1:0]        count,
  output oqi_pkg::scan_res_t           res,
  output logic      [SEG_W+oqi_pkg::LANE_W-1:0] pos
);
  import oqi_pkg::*;

  localparam int NSEG = (CAPACITY + SCAN_LANES - 1) / SCAN_LANES;
  localparam int PAD  = NSEG * SCAN_LANES;
  localparam int NS_W = SEG_W + LANE_W + 1;
  localparam int CW   = (NS_W > CNT_W) ? NS_W : CNT_W;

  logic [SEG_W-1:0]      seg_r;
  logic [SEG_W-1:0]      seg_nxt;
  logic [PAD-1:0]        match_pad;
  logic [SCAN_LANES-1:0] chunk;
  logic [LANE_W-1:0]     enc;
  logic [NS_W-1:0]       next_start;
  logic                  last;

  assign match_pad = PAD'(match_vec);
  assign chunk     = match_pad[seg_r*SCAN_LANES +: SCAN_LANES];

  always_comb begin
    enc = '0;
    for (int k = SCAN_LANES - 1; k >= 0; k--) begin
      if (chunk[k]) begin
        enc = LANE_W'(k);
      end
    end
  end

  assign next_start = {({1'b0, seg_r} + (SEG_W+1)'(1)), {LANE_W{1'b0}}};
  assign last = (seg_r == SEG_W'(NSEG - 1)) || (CW'(next_start) >= CW'(count));

  assign res.hit  = |chunk;
  assign res.done = busy && ((|chunk) || last);
  assign pos      = {seg_r, enc};

  always_comb begin
    seg_nxt = seg_r;
    if (start) begin
      seg_nxt = '0;
    end else if (busy && !res.done) begin
      seg_nxt = seg_r + SEG_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_r <= '0;
    end else begin
      seg_r <= seg_nxt;
    end
  end

endmodule

`default_nettype wire

/* src/ordered_queue_with_indexed_insert_top.sv */
// ordered queue of entry identifiers with append, indexed insert, head remove
// and search; depends on oqi_pkg, oqi_cell and oqi_scan
//
// usage:
//   in_* channel carries one command per transfer; out_* channel returns
//   exactly one result per command, in command order.
//   append, insert and remove complete in the cycle of the input transfer:
//   the result is registered into the result queue.
//   search compares all cells in the transfer cycle, then scans the match
//   flags eight cells per cycle, stopping at the first hit or at the end of
//   the occupied cells.
//   a new command is taken once the previous one has produced its result.
//   the output side has a two-entry result queue, so one command can still
//   be taken while an earlier result waits; with both entries full the input
//   stalls until the receiver takes a result. a stalled result holds steady.
//   reset empties the queue (occupancy zero) and the result queue; cell
//   contents are not cleared, cells past the occupancy are never read.
`default_nettype none

module ordered_queue_with_indexed_insert_top #(
  parameter int CAPACITY = 64,
  parameter int ID_WIDTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // opcode[1:0], item_id[17:2], position[25:18], zero[31:26]
  input  wire logic [31:0] in_tdata,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // status[2:0], result_id[18:3], result_position[25:19], occupancy[32:26],
  // zero[39:33]
  output logic [39:0]      out_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready
);
  import oqi_pkg::*;

  // stored id width: the id field is 16 bits wide
  localparam int SW    = (ID_WIDTH < ID_BITS) ? ID_WIDTH : ID_BITS;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > POS_BITS) ? CNT_W : POS_BITS;
  localparam int NSEG  = (CAPACITY + SCAN_LANES - 1) / SCAN_LANES;
  localparam int SEG_W = (NSEG > 1) ? $clog2(NSEG) : 1;
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  // input field decode
  opcode_t                 op;
  logic [SW-1:0]           in_id;
  logic [POSITION_BITS-1:0] in_pos;
  logic                    in_acc;

  assign op     = opcode_t'(in_tdata[1:0]);
  assign in_id  = in_tdata[2 +: SW];
  assign in_pos = in_tdata[18 +: POSITION_BITS];
  assign in_acc = in_tvalid && in_tready;

  // control state
  state_t            state_r;
  state_t            state_nxt;
  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  count_nxt;
  logic [SW-1:0]     key_r;
  logic [SW-1:0]     key_nxt;
  logic              scan_busy;

  // cell chain
  cell_ctl_t         ctl;
  logic [CNT_W-1:0]  at;
  logic [SW-1:0]     cell_data [CAPACITY];
  logic [CAPACITY-1:0] match_vec;
  logic [SW-1:0]     key_bus;

  // scanner
  scan_res_t                  scan_res;
  logic [SEG_W+LANE_W-1:0]    scan_pos;

  // result queue
  result_t res0_r, res0_nxt, res1_r, res1_nxt;
  logic    v0_r, v0_nxt, v1_r, v1_nxt;
  logic    push;
  result_t push_res;
  logic    pop;

  // compare helpers
  logic [CMP_W-1:0] pos_ext;
  logic [CMP_W-1:0] cnt_ext;
  logic             full;
  logic             empty;

  assign pos_ext = CMP_W'(in_pos[POSITION_BITS-2:0]);
  assign cnt_ext = CMP_W'(count_r);
  assign full    = (count_r == CAP_CNT);
  assign empty   = (count_r == '0);

  // compare key: new id in the transfer cycle, held id while scanning
  assign key_bus = in_acc ? in_id : key_r;

  // ---------------------------------------------------------------
  // command decode and results for append, insert, remove and finished searches
  // ---------------------------------------------------------------
  always_comb begin
    ctl       = '0;
    at        = count_r;
    count_nxt = count_r;
    key_nxt   = key_r;
    push      = 1'b0;
    push_res  = '0;
    push_res.status = ST_OK;
    if (in_acc) begin
      case (op)
        OP_APPEND: begin
          push = 1'b1;
          if (full) begin
            push_res.status = ST_FULL;
          end else begin
            ctl.ins   = 1'b1;
            count_nxt = count_r + CNT_W'(1);
            push_res.result_position = cnt_ext[POS_BITS-1:0];
          end
        end
        OP_INSERT: begin
          push = 1'b1;
          if (in_pos[POSITION_BITS-1]) begin
            push_res.status = ST_INVALID;
          end else if (full) begin
            push_res.status = ST_FULL;
          end else if (pos_ext > cnt_ext) begin
            // past the end goes to the tail
            ctl.ins   = 1'b1;
            count_nxt = count_r + CNT_W'(1);
            push_res.status          = ST_PAST_END;
            push_res.result_position = cnt_ext[POS_BITS-1:0];
          end else begin
            ctl.ins   = 1'b1;
            at        = pos_ext[CNT_W-1:0];
            count_nxt = count_r + CNT_W'(1);
            push_res.result_position = pos_ext[POS_BITS-1:0];
          end
        end
        OP_REMOVE: begin
          push = 1'b1;
          if (empty) begin
            push_res.status = ST_EMPTY;
          end else begin
            ctl.rem   = 1'b1;
            count_nxt = count_r - CNT_W'(1);
            push_res.result_id = ID_BITS'(cell_data[0]);
          end
        end
        OP_SEARCH: begin
          // result comes from the scanner
          ctl.srch = 1'b1;
          key_nxt  = in_id;
        end
        default: begin
          ctl = '0;
        end
      endcase
      push_res.occupancy = POS_BITS'(CMP_W'(count_nxt));
    end else if (scan_res.done) begin
      push = 1'b1;
      push_res.occupancy = POS_BITS'(CMP_W'(count_r));
      if (scan_res.hit) begin
        push_res.status          = ST_OK;
        push_res.result_id       = ID_BITS'(key_r);
        push_res.result_position = POS_BITS'(CMP_W'(scan_pos));
      end else begin
        push_res.status = ST_NOT_FOUND;
      end
    end
  end

  // ---------------------------------------------------------------
  // sequencer: next state
  // ---------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc && (op == OP_SEARCH)) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_res.done) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // sequencer: outputs
  always_comb begin
    in_tready = 1'b0;
    scan_busy = 1'b0;
    case (state_r)
      S_IDLE: begin
        // room for one more result keeps the input open
        in_tready = !v1_r;
      end
      S_SCAN: begin
        scan_busy = 1'b1;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  // ---------------------------------------------------------------
  // row of cells, each handing data to its neighbors
  // ---------------------------------------------------------------
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [SW-1:0] left_d;
    logic [SW-1:0] right_d;
    if (g == 0) begin : g_first
      assign left_d = key_bus;
    end else begin : g_mid_l
      assign left_d = cell_data[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right_d = '0;
    end else begin : g_mid_r
      assign right_d = cell_data[g+1];
    end
    oqi_cell #(
      .IDX   (g),
      .SW    (SW),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .key        (key_bus),
      .at         (at),
      .count      (count_r),
      .left_data  (left_d),
      .right_data (right_d),
      .data       (cell_data[g]),
      .match      (match_vec[g])
    );
  end

  oqi_scan #(
    .CAPACITY (CAPACITY),
    .CNT_W    (CNT_W),
    .SEG_W    (SEG_W)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (ctl.srch),
    .busy      (scan_busy),
    .match_vec (match_vec),
    .count     (count_r),
    .res       (scan_res),
    .pos       (scan_pos)
  );

  // ---------------------------------------------------------------
  // two-entry result queue in front of the output port
  // ---------------------------------------------------------------
  assign pop = v0_r && out_tready;

  always_comb begin
    res0_nxt = res0_r;
    res1_nxt = res1_r;
    v0_nxt   = v0_r;
    v1_nxt   = v1_r;
    if (pop) begin
      if (v1_r) begin
        res0_nxt = res1_r;
        v1_nxt   = 1'b0;
      end else begin
        v0_nxt = 1'b0;
      end
    end
    if (push) begin
      if (!v0_r || (pop && !v1_r)) begin
        res0_nxt = push_res;
        v0_nxt   = 1'b1;
      end else begin
        res1_nxt = push_res;
        v1_nxt   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      v0_r    <= 1'b0;
      v1_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      v0_r    <= v0_nxt;
      v1_r    <= v1_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res0_r <= res0_nxt;
    res1_r <= res1_nxt;
    key_r  <= key_nxt;
  end

  assign out_tvalid = v0_r;
  assign out_tdata  = OUT_BYTES_W'(res0_r);

endmodule

`default_nettype wire

/* src/oqi_chk.sv */
// port-level checker for the ordered queue block, bound to the top level
// depends on oqi_pkg and the assertion macro header
`include "ordered_queue_with_indexed_insert_top_assert.svh"
`default_nettype none

module oqi_chk #(
  parameter int CAPACITY = 64,
  parameter int ID_WIDTH = 16
) (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic [31:0] in_tdata,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic [39:0] out_tdata,
  input wire logic        out_tvalid,
  input wire logic        out_tready
);
  import oqi_pkg::*;

  localparam logic [6:0] CAP_OCC = 7'(CAPACITY);

  logic [2:0] st;
  logic [15:0] rid;
  logic [6:0] rpos;
  logic [6:0] occ;
  logic       in_xfer;

  assign st      = out_tdata[2:0];
  assign rid     = out_tdata[18:3];
  assign rpos    = out_tdata[25:19];
  assign occ     = out_tdata[32:26];
  assign in_xfer = in_tvalid && in_tready && (ID_WIDTH > 0);

  // stalled result holds
  `OQI_ASSERT_NEXT(a_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "stalled result changed")

  // a full rejection reports a full queue and no payload
  `OQI_ASSERT_NOW(a_full, clk, rst_n, out_tvalid && (st == ST_FULL), (occ == CAP_OCC) && (rid == '0) && (rpos == '0), "full status with wrong fields")

  // empty removal reports an empty queue
  `OQI_ASSERT_NOW(a_empty, clk, rst_n, out_tvalid && (st == ST_EMPTY), (occ == '0) && (rid == '0) && (rpos == '0), "empty status with wrong fields")

  // an idle block with no search running and no transfer raises no result
  `OQI_ASSERT_NOW(a_latency, clk, rst_n, $past(!out_tvalid) && $past(in_tready) && !$past(in_xfer) && $past(rst_n), !out_tvalid, "result without a command")

endmodule

bind ordered_queue_with_indexed_insert_top oqi_chk #(
  .CAPACITY (CAPACITY),
  .ID_WIDTH (ID_WIDTH)
) u_oqi_chk (.*);

`default_nettype wire
